/* src/fsc_pkg.sv */
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the fan speed thermostat controller
// Event codes, register indexes, the kept fan state and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

   localparam int KNOB_STEP    = 3;
   localparam int FULL_PERCENT = 100;
   localparam int POS_W        = 32;
   localparam int TEMP_W       = 12;
   localparam int LEVEL_W      = 8;
   localparam int LED_W        = 7;
   localparam int SPEED_W      = 3;
   localparam int CSR_INDEX_W  = 1;

   typedef enum logic [2:0] {
      KIND_KNOB         = 3'd0,
      KIND_BUTTON       = 3'd1,
      KIND_TEMPERATURE  = 3'd2,
      KIND_REMOTE_POWER = 3'd3,
      KIND_REMOTE_SPEED = 3'd4,
      KIND_REMOTE_LIGHT = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THERMO_ENABLE = 1'd0,
      CSR_THERMO_LEVEL  = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]              kind;
      logic signed [POS_W-1:0] knob_position;
      logic [1:0]              knob_direction;
      logic signed [TEMP_W-1:0] temperature;
      logic [2:0]              set_value;
   } item_type;

   typedef struct packed {
      logic                    power;
      logic [SPEED_W-1:0]      speed;
      logic                    light;
      logic signed [POS_W-1:0] last_knob;
   } fan_state_type;

   typedef struct packed {
      logic                    enable;
      logic signed [LEVEL_W-1:0] level;
   } thermo_cfg_type;

   typedef struct packed {
      logic               power_on;
      logic [SPEED_W-1:0] fan_speed;
      logic               light_on;
      logic               relay_cap_low_pin;
      logic               relay_cap_high_pin;
      logic               relay_direct_pin;
      logic               light_relay_pin;
      logic [LED_W-1:0]   led_red;
      logic [LED_W-1:0]   led_green;
      logic [LED_W-1:0]   led_blue;
      logic               report_power;
      logic               report_speed;
   } result_type;

endpackage

`default_nettype wire

/* src/fsc_event_logic.sv */
// ----------------------------------------------------------------------------
// fsc_event_logic: next fan state and result beat for one event
// Pure combinational update of speed, power, light and knob position.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_event_logic #(
   parameter int MAX_SPEED = 5
) (
   input  fsc_pkg::item_type       item,
   input  fsc_pkg::fan_state_type  cur_state,
   input  fsc_pkg::thermo_cfg_type cfg,
   output fsc_pkg::fan_state_type  nxt_state,
   output fsc_pkg::result_type     result
);
   import fsc_pkg::*;

   localparam logic [SPEED_W-1:0] MAX_SPD = SPEED_W'(MAX_SPEED);

   // LED percent per speed step, worked out at elaboration
   localparam logic [LED_W-1:0] LED_LEVEL [8] = '{
      LED_W'(0 * FULL_PERCENT / MAX_SPEED), LED_W'(1 * FULL_PERCENT / MAX_SPEED),
      LED_W'(2 * FULL_PERCENT / MAX_SPEED), LED_W'(3 * FULL_PERCENT / MAX_SPEED),
      LED_W'(4 * FULL_PERCENT / MAX_SPEED), LED_W'(5 * FULL_PERCENT / MAX_SPEED),
      LED_W'(0), LED_W'(0)
   };

   logic signed [POS_W:0]    knob_diff;
   logic                     knob_moved;
   logic [SPEED_W-1:0]       knob_speed;
   logic signed [TEMP_W:0]   temp_ext;
   logic signed [TEMP_W:0]   on_at;
   logic signed [TEMP_W:0]   off_at;
   logic [SPEED_W-1:0]       remote_speed;
   logic [SPEED_W-1:0]       drive;
   logic                     rep_power;
   logic                     rep_speed;

   always_comb begin
      knob_diff  = {cur_state.last_knob[POS_W-1], cur_state.last_knob}
                 - {item.knob_position[POS_W-1], item.knob_position};
      knob_moved = (knob_diff >= (POS_W+1)'(KNOB_STEP))
                || (knob_diff <= -(POS_W+1)'(KNOB_STEP));

      knob_speed = cur_state.speed;
      if (item.knob_direction == DIR_CW && cur_state.speed < MAX_SPD) begin
         knob_speed = cur_state.speed + 3'd1;
      end else if (item.knob_direction == DIR_CCW && cur_state.speed != '0) begin
         knob_speed = cur_state.speed - 3'd1;
      end

      temp_ext = {item.temperature[TEMP_W-1], item.temperature};
      on_at    = {cfg.level[LEVEL_W-1], cfg.level, 4'b0000};
      off_at   = on_at - (TEMP_W+1)'(16);

      remote_speed = (item.set_value > MAX_SPD) ? MAX_SPD : item.set_value;

      nxt_state = cur_state;
      rep_power = 1'b0;
      rep_speed = 1'b0;

      unique case (item.kind)
         KIND_KNOB: begin
            if (knob_moved) begin
               nxt_state.last_knob = item.knob_position;
               nxt_state.speed     = knob_speed;
               if (knob_speed != cur_state.speed) begin
                  rep_speed = 1'b1;
                  if (cur_state.speed == '0 || (!cur_state.power && knob_speed != '0)) begin
                     nxt_state.power = 1'b1;
                     rep_power       = 1'b1;
                  end else if (knob_speed == '0) begin
                     nxt_state.power = 1'b0;
                     rep_power       = 1'b1;
                  end
               end
            end
         end
         KIND_BUTTON: begin
            nxt_state.light = !cur_state.light;
         end
         KIND_TEMPERATURE: begin
            if (cfg.enable) begin
               if (!cur_state.power) begin
                  if (temp_ext > on_at) begin
                     nxt_state.power = 1'b1;
                     rep_power       = 1'b1;
                  end
               end else if (temp_ext < off_at) begin
                  nxt_state.power = 1'b0;
                  rep_power       = 1'b1;
               end
            end
         end
         KIND_REMOTE_POWER: begin
            nxt_state.power = (item.set_value != '0);
         end
         KIND_REMOTE_SPEED: begin
            nxt_state.speed = remote_speed;
            if (remote_speed != '0 && !cur_state.power) begin
               nxt_state.power = 1'b1;
               rep_power       = 1'b1;
            end else if (remote_speed == '0 && cur_state.power) begin
               nxt_state.power = 1'b0;
               rep_power       = 1'b1;
            end
         end
         KIND_REMOTE_LIGHT: begin
            nxt_state.light = (item.set_value != '0);
         end
         default: begin
            nxt_state = cur_state;
         end
      endcase

      // outputs follow the state after the event
      drive = nxt_state.power ? nxt_state.speed : '0;

      result.power_on           = nxt_state.power;
      result.fan_speed          = nxt_state.speed;
      result.light_on           = nxt_state.light;
      result.relay_cap_low_pin  = !(drive == 3'd1 || drive == 3'd3);
      result.relay_cap_high_pin = !(drive == 3'd2 || drive == 3'd3);
      result.relay_direct_pin   = !(drive == 3'd4 || drive == 3'd5);
      result.light_relay_pin    = !nxt_state.light;
      result.led_red            = '0;
      result.led_green          = '0;
      result.led_blue           = '0;
      if (nxt_state.power && nxt_state.speed != '0) begin
         if (nxt_state.light) begin
            result.led_green = LED_LEVEL[nxt_state.speed];
         end else begin
            result.led_red = LED_LEVEL[nxt_state.speed];
         end
      end else if (nxt_state.light) begin
         result.led_blue = LED_W'(FULL_PERCENT);
      end
      result.report_power = rep_power;
      result.report_speed = rep_speed;
   end

endmodule

`default_nettype wire

/* src/fan_speed_thermostat_controller_unit.sv */
// ----------------------------------------------------------------------------
// fan_speed_thermostat_controller_unit: ceiling fan controller top level
// Event input stage, state update, registered result beat and CSR port.
// ----------------------------------------------------------------------------
`default_nettype none

// Each request beat carries one event (knob move, button tap, temperature
// sample or a remote power, speed or light command) and yields exactly one
// response beat with the fan state after the event, the active-low relay
// pins, the status LED color and the two report flags. The block is a
// two-register pipeline: a request register captures the beat, then the
// state update and output decode run in one combinational pass into the
// response register. It takes one beat per cycle while req_stall is low; a
// response is offered once its beat has moved from the request register
// into the response register and is taken at an edge with rsp_stall low. The
// request register keeps taking beats while a finished response waits, and
// req_stall rises only when both registers hold beats and the response side
// stalls. Write the thermostat registers through the csr_ port while no
// beat is in flight; index 0 is the thermostat enable, index 1 the signed
// switch-on level in whole degrees. MAX_SPEED sets the top speed step (1..5).

module fan_speed_thermostat_controller_unit #(
   parameter int MAX_SPEED = 5
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [2:0]                          req_kind,
   input  wire logic signed [fsc_pkg::POS_W-1:0]    req_knob_position,
   input  wire logic [1:0]                          req_knob_direction,
   input  wire logic signed [fsc_pkg::TEMP_W-1:0]   req_temperature,
   input  wire logic [2:0]                          req_set_value,
   // response channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_power_on,
   output      logic [fsc_pkg::SPEED_W-1:0]         rsp_fan_speed,
   output      logic                                rsp_light_on,
   output      logic                                rsp_relay_cap_low_pin,
   output      logic                                rsp_relay_cap_high_pin,
   output      logic                                rsp_relay_direct_pin,
   output      logic                                rsp_light_relay_pin,
   output      logic [fsc_pkg::LED_W-1:0]           rsp_led_red,
   output      logic [fsc_pkg::LED_W-1:0]           rsp_led_green,
   output      logic [fsc_pkg::LED_W-1:0]           rsp_led_blue,
   output      logic                                rsp_report_power,
   output      logic                                rsp_report_speed,
   // configuration port
   input  wire logic                                csr_wr_en,
   input  wire logic [fsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fsc_pkg::LEVEL_W-1:0]         csr_wr_data
);
   import fsc_pkg::*;

   localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = 8'sd25;

   logic           req_vld_ff, req_vld_in;
   item_type       item_ff, item_in;
   logic           rsp_vld_ff, rsp_vld_in;
   result_type     result_ff, result_in;
   fan_state_type  state_ff, state_in;
   fan_state_type  nxt_state;
   thermo_cfg_type cfg_ff, cfg_in;
   logic           req_take;
   logic           rsp_take;
   logic           advance;

   // move the held request into the response register when it is free or
   // being emptied this cycle
   assign rsp_take  = rsp_vld_ff && !rsp_stall;
   assign advance   = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   fsc_event_logic #(
      .MAX_SPEED (MAX_SPEED)
   ) u_event (
      .item      (item_ff),
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .nxt_state (nxt_state),
      .result    (result_in)
   );

   always_comb begin
      req_vld_in = req_vld_ff;
      if (req_take) begin
         req_vld_in = 1'b1;
      end else if (advance) begin
         req_vld_in = 1'b0;
      end

      item_in = item_ff;
      if (req_take) begin
         item_in.kind           = req_kind;
         item_in.knob_position  = req_knob_position;
         item_in.knob_direction = req_knob_direction;
         item_in.temperature    = req_temperature;
         item_in.set_value      = req_set_value;
      end

      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_take) begin
         rsp_vld_in = 1'b0;
      end

      // commit the state only when the beat moves on, so each event sees
      // the state left by the one before it
      state_in = advance ? nxt_state : state_ff;

      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_THERMO_ENABLE: cfg_in.enable = csr_wr_data[0];
            CSR_THERMO_LEVEL:  cfg_in.level  = csr_wr_data;
            default:           cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff         <= 1'b0;
         rsp_vld_ff         <= 1'b0;
         state_ff.power     <= 1'b0;
         state_ff.speed     <= '0;
         state_ff.light     <= 1'b0;
         state_ff.last_knob <= '0;
         cfg_ff.enable      <= 1'b0;
         cfg_ff.level       <= LEVEL_RESET;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
         cfg_ff     <= cfg_in;
      end
   end

   // payload registers: hold unless a new beat lands
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid              = rsp_vld_ff;
   assign rsp_power_on           = result_ff.power_on;
   assign rsp_fan_speed          = result_ff.fan_speed;
   assign rsp_light_on           = result_ff.light_on;
   assign rsp_relay_cap_low_pin  = result_ff.relay_cap_low_pin;
   assign rsp_relay_cap_high_pin = result_ff.relay_cap_high_pin;
   assign rsp_relay_direct_pin   = result_ff.relay_direct_pin;
   assign rsp_light_relay_pin    = result_ff.light_relay_pin;
   assign rsp_led_red            = result_ff.led_red;
   assign rsp_led_green          = result_ff.led_green;
   assign rsp_led_blue           = result_ff.led_blue;
   assign rsp_report_power       = result_ff.report_power;
   assign rsp_report_speed       = result_ff.report_speed;

endmodule

`default_nettype wire

/* bench/fsc_checker.sv */
// ----------------------------------------------------------------------------
// fan_status_checker: fan controller status predictor and comparator
// Watches the request, response and CSR ports, keeps its own copy of the fan
// state and thermostat settings, and checks every response beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_status_checker #(
   parameter int MAX_SPEED = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic [2:0]                        req_kind,
   input  wire logic signed [fsc_pkg::POS_W-1:0]  req_knob_position,
   input  wire logic [1:0]                        req_knob_direction,
   input  wire logic signed [fsc_pkg::TEMP_W-1:0] req_temperature,
   input  wire logic [2:0]                        req_set_value,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic                              rsp_power_on,
   input  wire logic [fsc_pkg::SPEED_W-1:0]       rsp_fan_speed,
   input  wire logic                              rsp_light_on,
   input  wire logic                              rsp_relay_cap_low_pin,
   input  wire logic                              rsp_relay_cap_high_pin,
   input  wire logic                              rsp_relay_direct_pin,
   input  wire logic                              rsp_light_relay_pin,
   input  wire logic [fsc_pkg::LED_W-1:0]         rsp_led_red,
   input  wire logic [fsc_pkg::LED_W-1:0]         rsp_led_green,
   input  wire logic [fsc_pkg::LED_W-1:0]         rsp_led_blue,
   input  wire logic                              rsp_report_power,
   input  wire logic                              rsp_report_speed,
   input  wire logic                              csr_wr_en,
   input  wire logic [fsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [fsc_pkg::LEVEL_W-1:0]       csr_wr_data,
   output int                                     mismatch_count,
   output int                                     status_pending
);
   import fsc_pkg::*;

   localparam int SIXTEENTHS = 16;

   fan_state_type  fan;
   thermo_cfg_type thermo;
   result_type     expected_status[$];

   // Apply one event to the fan state and work out the status beat it yields.
   function automatic result_type advance_fan(input item_type ev);
      result_type         r;
      longint             span;
      logic [SPEED_W-1:0] prior;
      int                 temp_now;
      int                 on_at;
      int                 off_at;
      int unsigned        drive;
      int unsigned        pct;
      r = '0;
      unique case (ev.kind)
         KIND_KNOB: begin
            span = longint'(fan.last_knob) - longint'(ev.knob_position);
            if (span < 0) span = -span;
            if (span >= KNOB_STEP) begin
               prior = fan.speed;
               if (ev.knob_direction == DIR_CW && fan.speed < MAX_SPEED)
                  fan.speed = fan.speed + 1'b1;
               else if (ev.knob_direction == DIR_CCW && fan.speed > 0)
                  fan.speed = fan.speed - 1'b1;
               if (prior != fan.speed) begin
                  r.report_speed = 1'b1;
                  if (prior == 0 || (!fan.power && fan.speed > 0)) begin
                     fan.power      = 1'b1;
                     r.report_power = 1'b1;
                  end else if (fan.speed == 0) begin
                     fan.power      = 1'b0;
                     r.report_power = 1'b1;
                  end
               end
               fan.last_knob = ev.knob_position;
            end
         end
         KIND_BUTTON: fan.light = ~fan.light;
         KIND_TEMPERATURE: begin
            if (thermo.enable) begin
               temp_now = int'(ev.temperature);
               on_at    = int'(thermo.level) * SIXTEENTHS;
               off_at   = (int'(thermo.level) - 1) * SIXTEENTHS;
               if (!fan.power) begin
                  if (temp_now > on_at) begin
                     fan.power      = 1'b1;
                     r.report_power = 1'b1;
                  end
               end else if (temp_now < off_at) begin
                  fan.power      = 1'b0;
                  r.report_power = 1'b1;
               end
            end
         end
         KIND_REMOTE_POWER: fan.power = (ev.set_value != 0);
         KIND_REMOTE_SPEED: begin
            fan.speed = (ev.set_value > MAX_SPEED) ? SPEED_W'(MAX_SPEED) : ev.set_value;
            if (fan.speed > 0 && !fan.power) begin
               fan.power      = 1'b1;
               r.report_power = 1'b1;
            end else if (fan.speed == 0 && fan.power) begin
               fan.power      = 1'b0;
               r.report_power = 1'b1;
            end
         end
         KIND_REMOTE_LIGHT: fan.light = (ev.set_value != 0);
         default: ;
      endcase

      drive = fan.power ? int'(fan.speed) : 0;
      pct   = int'(fan.speed) * FULL_PERCENT / MAX_SPEED;
      r.power_on           = fan.power;
      r.fan_speed          = fan.speed;
      r.light_on           = fan.light;
      r.relay_cap_low_pin  = !(drive == 1 || drive == 3);
      r.relay_cap_high_pin = !(drive == 2 || drive == 3);
      r.relay_direct_pin   = !(drive == 4 || drive == 5);
      r.light_relay_pin    = !fan.light;
      if (fan.speed > 0 && fan.power) begin
         if (fan.light) r.led_green = LED_W'(pct);
         else r.led_red = LED_W'(pct);
      end else if (fan.light) begin
         r.led_blue = LED_W'(FULL_PERCENT);
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      item_type   ev;
      result_type want;
      if (reset) begin
         fan          = '0;
         thermo       = '0;
         thermo.level = 8'sd25;
         expected_status.delete();
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_THERMO_ENABLE: thermo.enable = csr_wr_data[0];
               CSR_THERMO_LEVEL:  thermo.level  = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("response beat arrived with no status expected");
               mismatch_count++;
            end else begin
               want = expected_status.pop_front();
               check_field("power_on", want.power_on, rsp_power_on);
               check_field("fan_speed", want.fan_speed, rsp_fan_speed);
               check_field("light_on", want.light_on, rsp_light_on);
               check_field("relay_cap_low_pin", want.relay_cap_low_pin,
                           rsp_relay_cap_low_pin);
               check_field("relay_cap_high_pin", want.relay_cap_high_pin,
                           rsp_relay_cap_high_pin);
               check_field("relay_direct_pin", want.relay_direct_pin,
                           rsp_relay_direct_pin);
               check_field("light_relay_pin", want.light_relay_pin, rsp_light_relay_pin);
               check_field("led_red", want.led_red, rsp_led_red);
               check_field("led_green", want.led_green, rsp_led_green);
               check_field("led_blue", want.led_blue, rsp_led_blue);
               check_field("report_power", want.report_power, rsp_report_power);
               check_field("report_speed", want.report_speed, rsp_report_speed);
            end
         end
         if (req_valid && !req_stall) begin
            ev.kind           = req_kind;
            ev.knob_position  = req_knob_position;
            ev.knob_direction = req_knob_direction;
            ev.temperature    = req_temperature;
            ev.set_value      = req_set_value;
            expected_status.push_back(advance_fan(ev));
         end
      end
      status_pending = expected_status.size();
   end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: fan speed thermostat controller testbench
// Drives event beats and thermostat settings into the controller, stalls the
// response side at random, and takes its verdict from the status checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import fsc_pkg::*;

   localparam int FAN_MAX_SPEED   = 5;
   localparam int HALF_PERIOD     = 2;
   localparam int PHASES          = 6;
   localparam int BEATS_PER_PHASE = 87;
   localparam int LONG_HOLD       = 300;
   localparam int QUIET_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 8;

   // Codes the block must tolerate but that have no name in the package.
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;
   localparam logic [1:0] DIR_SPARE    = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid;
   logic                     req_stall;
   logic [2:0]               req_kind;
   logic signed [POS_W-1:0]  req_knob_position;
   logic [1:0]               req_knob_direction;
   logic signed [TEMP_W-1:0] req_temperature;
   logic [2:0]               req_set_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_power_on;
   logic [SPEED_W-1:0]       rsp_fan_speed;
   logic                     rsp_light_on;
   logic                     rsp_relay_cap_low_pin;
   logic                     rsp_relay_cap_high_pin;
   logic                     rsp_relay_direct_pin;
   logic                     rsp_light_relay_pin;
   logic [LED_W-1:0]         rsp_led_red;
   logic [LED_W-1:0]         rsp_led_green;
   logic [LED_W-1:0]         rsp_led_blue;
   logic                     rsp_report_power;
   logic                     rsp_report_speed;
   logic                     csr_wr_en;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [LEVEL_W-1:0]       csr_wr_data;

   int                       mismatch_count;
   int                       status_pending;
   int                       quiet_cycles = 0;
   int                       knob_cursor = 0;
   bit                       idle_on = 1'b0;
   bit                       long_hold = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   fan_speed_thermostat_controller_unit #(.MAX_SPEED(FAN_MAX_SPEED)) uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_knob_position      (req_knob_position),
      .req_knob_direction     (req_knob_direction),
      .req_temperature        (req_temperature),
      .req_set_value          (req_set_value),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_power_on           (rsp_power_on),
      .rsp_fan_speed          (rsp_fan_speed),
      .rsp_light_on           (rsp_light_on),
      .rsp_relay_cap_low_pin  (rsp_relay_cap_low_pin),
      .rsp_relay_cap_high_pin (rsp_relay_cap_high_pin),
      .rsp_relay_direct_pin   (rsp_relay_direct_pin),
      .rsp_light_relay_pin    (rsp_light_relay_pin),
      .rsp_led_red            (rsp_led_red),
      .rsp_led_green          (rsp_led_green),
      .rsp_led_blue           (rsp_led_blue),
      .rsp_report_power       (rsp_report_power),
      .rsp_report_speed       (rsp_report_speed),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data)
   );

   fan_status_checker #(.MAX_SPEED(FAN_MAX_SPEED)) status_check (.*);

   // Watchdog: count cycles in which neither channel moves a beat. The long
   // receiver hold-off is far below the limit, so only a hang trips it.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("fan_speed_thermostat_controller_unit: mismatch");
            $finish;
         end
      end
   end

   // Response side: decide the stall for the next cycle at each falling edge.
   // A requested long hold-off takes priority; otherwise stall in random
   // bursts while idling is on, and never once it is off.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic item_type event_of(input logic [2:0] kind, input logic [31:0] pos,
                                         input logic [1:0] dir, input logic [11:0] temp,
                                         input logic [2:0] setv);
      item_type ev;
      ev.kind           = kind;
      ev.knob_position  = pos;
      ev.knob_direction = dir;
      ev.temperature    = temp;
      ev.set_value      = setv;
      return ev;
   endfunction

   // Random event. Knob moves walk a cursor in small steps so that the
   // three-count threshold is hit and missed often; now and then the cursor
   // jumps anywhere in the 32-bit range. Temperatures cluster around the
   // switch points of the current level, with some drawn from the full field.
   function automatic item_type random_event(input logic signed [7:0] level);
      item_type ev;
      int       roll;
      int       t;
      ev   = event_of(3'($urandom), $urandom, 2'($urandom), 12'($urandom), 3'($urandom));
      roll = $urandom_range(0, 99);
      if (roll < 35)      ev.kind = KIND_KNOB;
      else if (roll < 45) ev.kind = KIND_BUTTON;
      else if (roll < 65) ev.kind = KIND_TEMPERATURE;
      else if (roll < 73) ev.kind = KIND_REMOTE_POWER;
      else if (roll < 85) ev.kind = KIND_REMOTE_SPEED;
      else if (roll < 95) ev.kind = KIND_REMOTE_LIGHT;
      else                ev.kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_B));
      if (ev.kind == KIND_KNOB) begin
         if ($urandom_range(0, 9) == 0) knob_cursor = int'($urandom);
         else knob_cursor = knob_cursor + int'($urandom_range(0, 12)) - 6;
         ev.knob_position = knob_cursor;
         if ($urandom_range(0, 9) != 0) ev.knob_direction = 2'($urandom_range(1, 2));
      end
      if (ev.kind == KIND_TEMPERATURE && $urandom_range(0, 4) != 0) begin
         t = int'(level) * 16 + int'($urandom_range(0, 64)) - 48;
         ev.temperature = 12'(t);
      end
      return ev;
   endfunction

   // Offer one beat, with an optional idle burst first carrying junk payload.
   // Return at the falling edge after acceptance so the caller drives next.
   task automatic send_beat(input item_type ev);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid          = 1'b0;
         req_kind           = 3'($urandom);
         req_knob_position  = $urandom;
         req_knob_direction = 2'($urandom);
         req_temperature    = 12'($urandom);
         req_set_value      = 3'($urandom);
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid          = 1'b1;
      req_kind           = ev.kind;
      req_knob_position  = ev.knob_position;
      req_knob_direction = ev.knob_direction;
      req_temperature    = ev.temperature;
      req_set_value      = ev.set_value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected status beat has come back.
   task automatic drain_status();
      req_valid = 1'b0;
      while (status_pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   initial begin : stimulus
      logic signed [7:0] level_now;
      bit                enable_now;
      req_valid          = 1'b0;
      req_kind           = '0;
      req_knob_position  = '0;
      req_knob_direction = '0;
      req_temperature    = '0;
      req_set_value      = '0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_THERMO_ENABLE;
      csr_wr_data        = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the reset thermostat settings (disabled, 25 C).
      // Light by tap and by remote.
      send_beat(event_of(KIND_BUTTON, 0, DIR_NONE, 0, 0));
      send_beat(event_of(KIND_REMOTE_LIGHT, 0, DIR_NONE, 0, 0));
      send_beat(event_of(KIND_REMOTE_LIGHT, 0, DIR_NONE, 0, 7));
      // Knob: a move of two is too short, three counts and powers up from
      // speed zero, a move with no direction only updates the position.
      send_beat(event_of(KIND_KNOB, 2, DIR_CW, 0, 0));
      send_beat(event_of(KIND_KNOB, 3, DIR_CW, 0, 0));
      send_beat(event_of(KIND_KNOB, -32'sd3, DIR_NONE, 0, 0));
      // Position extremes: the distance must be taken without overflow.
      send_beat(event_of(KIND_KNOB, 32'h7FFF_FFFF, DIR_CW, 0, 0));
      send_beat(event_of(KIND_KNOB, 32'h8000_0000, DIR_CW, 0, 0));
      send_beat(event_of(KIND_KNOB, 100, DIR_SPARE, 0, 0));
      // Climb to the top speed and push once more against the ceiling.
      send_beat(event_of(KIND_KNOB, 200, DIR_CW, 0, 0));
      send_beat(event_of(KIND_KNOB, 300, DIR_CW, 0, 0));
      send_beat(event_of(KIND_KNOB, 400, DIR_CW, 0, 0));
      // Knob down with power off turns power back on.
      send_beat(event_of(KIND_REMOTE_POWER, 0, DIR_NONE, 0, 0));
      send_beat(event_of(KIND_KNOB, 500, DIR_CCW, 0, 0));
      // Remote speed zero, then the knob against the floor.
      send_beat(event_of(KIND_REMOTE_SPEED, 0, DIR_NONE, 0, 0));
      send_beat(event_of(KIND_KNOB, 497, DIR_CCW, 0, 0));
      // Power on at speed zero, then a knob step from zero rewrites power
      // to the same value and still reports it; stepping back turns it off.
      send_beat(event_of(KIND_REMOTE_POWER, 0, DIR_NONE, 0, 1));
      send_beat(event_of(KIND_KNOB, 494, DIR_CW, 0, 0));
      send_beat(event_of(KIND_KNOB, 491, DIR_CCW, 0, 0));
      // Remote speed beyond the top saturates, then a plain mid speed.
      send_beat(event_of(KIND_REMOTE_SPEED, 0, DIR_NONE, 0, 7));
      send_beat(event_of(KIND_REMOTE_SPEED, 0, DIR_NONE, 0, 3));
      send_beat(event_of(KIND_REMOTE_LIGHT, 0, DIR_NONE, 0, 0));
      send_beat(event_of(KIND_BUTTON, 0, DIR_NONE, 0, 0));
      // Unused kinds, and a hot sample while the thermostat is off.
      send_beat(event_of(KIND_SPARE_A, 0, DIR_NONE, 0, 0));
      send_beat(event_of(KIND_SPARE_B, 0, DIR_NONE, 0, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'sd2047, 0));

      // Thermostat at the top of the level range: hit both switch points
      // exactly and one sixteenth past them.
      drain_status();
      write_reg(CSR_THERMO_ENABLE, 8'h01);
      write_reg(CSR_THERMO_LEVEL, 8'sd125);
      send_beat(event_of(KIND_REMOTE_POWER, 0, DIR_NONE, 0, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'sd2000, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'sd2001, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'sd1984, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'sd1983, 0));

      // Bottom of the level range, down to the coldest sample.
      drain_status();
      write_reg(CSR_THERMO_LEVEL, -8'sd40);
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, -12'sd640, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, -12'sd639, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, -12'sd656, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'h800, 0));

      // Enable writes only look at bit 0; then the register extremes.
      drain_status();
      write_reg(CSR_THERMO_ENABLE, 8'hFE);
      write_reg(CSR_THERMO_LEVEL, 8'sd127);
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'sd2047, 0));
      drain_status();
      write_reg(CSR_THERMO_ENABLE, 8'hFF);
      write_reg(CSR_THERMO_LEVEL, 8'h80);
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'sd2047, 0));
      send_beat(event_of(KIND_TEMPERATURE, 0, DIR_NONE, 12'h800, 0));

      // Random part, one thermostat setting per phase. Phase 1 opens with a
      // long receiver hold-off while beats keep coming, phase 2 pauses the
      // sender halfway until the pipeline is empty, the last phase has no
      // idling on either side.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_status();
         enable_now = (phase == 2) ? 1'b0 : ((phase == 4) ? 1'($urandom) : 1'b1);
         case (phase)
            0:       level_now = 8'sd25;
            1:       level_now = -8'sd128;
            2:       level_now = 8'sd127;
            3:       level_now = -8'sd40;
            4:       level_now = 8'sd125;
            default: level_now = 8'($urandom_range(0, 165) - 40);
         endcase
         write_reg(CSR_THERMO_ENABLE, {7'($urandom), enable_now});
         write_reg(CSR_THERMO_LEVEL, level_now);
         idle_on = (phase != PHASES - 1);
         if (phase == 1) long_hold = 1'b1;
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            if (phase == 2 && n == BEATS_PER_PHASE / 2) drain_status();
            send_beat(random_event(level_now));
         end
      end

      drain_status();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("fan_speed_thermostat_controller_unit: match");
      end else begin
         $display("fan_speed_thermostat_controller_unit: mismatch");
      end
      $finish;
   end

endmodule
